### rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/tfrep_pkg.sv
// Shared types, constants and saturation helpers for the eigen projection block.
// No dependencies.
`default_nettype none
package tfrep_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = WORD_W + FRAC_BITS;
  localparam int ACC_W     = PROD_W + 4;
  localparam int CFG_W     = 31;

  localparam int DIV_STEPS  = PROD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int SQRT_STEPS = PROD_W / 2;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_FLUID  = 2'd1;
  localparam logic [1:0] OP_FIELD  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic CFG_GAMMA = 1'b0;
  localparam logic CFG_LIGHT = 1'b1;

  localparam logic [CFG_W-1:0] GAMMA_RST = CFG_W'(109227);
  localparam logic [CFG_W-1:0] LIGHT_RST = CFG_W'(65536);

  localparam word_t WMAX    = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WMIN    = {1'b1, {(WORD_W-1){1'b0}}};
  localparam acc_t  ONE_ACC = acc_t'(1) <<< FRAC_BITS;

  localparam logic [PROD_W-1:0] Q_NEG_LIM = PROD_W'(1) << (WORD_W-1);
  localparam logic [PROD_W-1:0] Q_POS_LIM = Q_NEG_LIM - PROD_W'(1);

  typedef struct packed {
    logic  start;
    word_t num;
    word_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t q;
    logic  ovf;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-2:0] arg;
  } sqrt_req_t;

  typedef struct packed {
    logic  done;
    word_t root;
  } sqrt_rsp_t;

  function automatic acc_t ext_w(input word_t x);
    return {{(ACC_W-WORD_W){x[WORD_W-1]}}, x};
  endfunction

  function automatic acc_t ext_p(input prod_t x);
    return {{(ACC_W-PROD_W){x[PROD_W-1]}}, x};
  endfunction

  function automatic logic ovf_w(input acc_t x);
    logic [ACC_W-WORD_W:0] hi;
    hi = x[ACC_W-1:WORD_W-1];
    return !((&hi) || !(|hi));
  endfunction

  function automatic word_t sat_w(input acc_t x);
    if (ovf_w(x)) begin
      return x[ACC_W-1] ? WMIN : WMAX;
    end
    return x[WORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/core/tfrep_mul.sv
// Shared fixed-point multiplier: full product, floor shift, registered.
// Depends on tfrep_pkg.
`default_nettype none
module tfrep_mul import tfrep_pkg::*; (
  input  wire logic  clk,
  input  wire word_t a_i,
  input  wire word_t b_i,
  output prod_t      prod_r
);

  logic signed [2*WORD_W-1:0] full;
  prod_t                      prod_nxt;

  assign full     = a_i * b_i;
  // arithmetic shift by the fraction rounds toward minus infinity
  assign prod_nxt = full[2*WORD_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule
`default_nettype wire

### rtl/core/tfrep_div.sv
// Bit-serial restoring divider: num * 2^FRAC_BITS / den, truncated, saturated.
// Depends on tfrep_pkg.
`default_nettype none
module tfrep_div import tfrep_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic [WORD_W-1:0]    den_r, den_nxt;
  logic [PROD_W-1:0]    dvd_r, dvd_nxt;
  logic [WORD_W-1:0]    rem_r, rem_nxt;
  logic [PROD_W-1:0]    q_r, q_nxt;
  word_t                qo_r, qo_nxt;
  logic                 ovf_r, ovf_nxt;

  always_comb begin
    logic [WORD_W:0]     rem_t;
    logic                ge;
    logic [PROD_W-1:0]   q_n;
    logic [WORD_W-1:0]   mag;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    den_nxt  = den_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    qo_nxt   = qo_r;
    ovf_nxt  = ovf_r;
    rem_t    = {rem_r, dvd_r[PROD_W-1]};
    ge       = rem_t >= {1'b0, den_r};
    q_n      = {q_r[PROD_W-2:0], ge};
    mag      = req.num[WORD_W-1] ? (~req.num + WORD_W'(1)) : req.num;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = req.num[WORD_W-1];
      den_nxt  = req.den;
      dvd_nxt  = {mag, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? WORD_W'(rem_t - {1'b0, den_r}) : rem_t[WORD_W-1:0];
      q_nxt   = q_n;
      dvd_nxt = {dvd_r[PROD_W-2:0], 1'b0};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_STEPS-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (neg_r) begin
          ovf_nxt = q_n > Q_NEG_LIM;
          qo_nxt  = ovf_nxt ? WMIN : (~q_n[WORD_W-1:0] + WORD_W'(1));
        end else begin
          ovf_nxt = q_n > Q_POS_LIM;
          qo_nxt  = ovf_nxt ? WMAX : q_n[WORD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    den_r <= den_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    qo_r  <= qo_nxt;
    ovf_r <= ovf_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = qo_r;
  assign rsp.ovf  = ovf_r;

endmodule
`default_nettype wire

### rtl/core/tfrep_sqrt.sv
// Digit-by-digit square root of arg * 2^FRAC_BITS, two radicand bits a cycle.
// Depends on tfrep_pkg.
`default_nettype none
module tfrep_sqrt import tfrep_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire sqrt_req_t req,
  output sqrt_rsp_t      rsp
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [SQRT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PROD_W-1:0]     x_r, x_nxt;
  logic [SQRT_STEPS+1:0] rem_r, rem_nxt;
  logic [SQRT_STEPS-1:0] root_r, root_nxt;

  always_comb begin
    logic [SQRT_STEPS+3:0] rem_t;
    logic [SQRT_STEPS+3:0] trial;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem_t    = {rem_r, x_r[PROD_W-1:PROD_W-2]};
    trial    = {2'b00, root_r, 2'b01};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = {1'b0, req.arg, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      x_nxt   = {x_r[PROD_W-3:0], 2'b00};
      cnt_nxt = cnt_r + SQRT_CNT_W'(1);
      if (rem_t >= trial) begin
        rem_nxt  = (SQRT_STEPS+2)'(rem_t - trial);
        root_nxt = {root_r[SQRT_STEPS-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_t[SQRT_STEPS+1:0];
        root_nxt = {root_r[SQRT_STEPS-2:0], 1'b0};
      end
      if (cnt_r == SQRT_CNT_W'(SQRT_STEPS-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = {{(WORD_W-SQRT_STEPS){1'b0}}, root_r};

endmodule
`default_nettype wire

### rtl/core/two_fluid_right_eigen_projection_top.sv
// Two-fluid right eigenvector projection, Q16.16 signed fixed point.
// Input channel (in_*): one beat is an opcode, a species and six values.
//   Load (opcode 0) derives and stores velocities, sound speed, enthalpy and
//   half squared speed of a species; fluid (1) projects five characteristic
//   values on the stored species; field (2) maps six field values with the
//   light speed; opcode 3 returns an all-zero result.
// Output channel (out_*): exactly one result beat per input beat, in order.
// Configuration (cfg_*): write gamma (index 0) or light speed (index 1) while idle.
// Work per item: a load runs five serial divisions, a square root and
//   sequencing steps before the hand-off; fluid and field are sequenced
//   through one registered multiplier; opcode 3 and a nonpositive-density
//   load skip the arithmetic.
// in_stall is high from accept until the result moves to the output
// register; the next beat can be taken while that result still waits.
// A stalled result holds; a finished item then waits before the output.
// Reset (synchronous, active low) clears both species' state to zero and
// restores gamma 109227 and light speed 65536.
// Depends on tfrep_pkg, tfrep_mul, tfrep_div, tfrep_sqrt.
`default_nettype none
module two_fluid_right_eigen_projection_top import tfrep_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_opcode,
  input  wire logic              in_species,
  input  wire word_t             in_val_0,
  input  wire word_t             in_val_1,
  input  wire word_t             in_val_2,
  input  wire word_t             in_val_3,
  input  wire word_t             in_val_4,
  input  wire word_t             in_val_5,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output word_t                  out_res_0,
  output word_t                  out_res_1,
  output word_t                  out_res_2,
  output word_t                  out_res_3,
  output word_t                  out_res_4,
  output word_t                  out_res_5,
  output logic                   out_density_fault,
  output logic                   out_saturated,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_WAIT,
    S_FAULT,
    S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [1:0]  op_r, op_nxt;
  logic        sp_r, sp_nxt;
  word_t       w_r [6];
  word_t       w_nxt [6];
  word_t       r_r [6];
  word_t       r_nxt [6];
  logic        fault_r, fault_nxt;
  logic        flag_r, flag_nxt;
  acc_t        acc_r, acc_nxt;
  word_t       tmp_r, tmp_nxt;
  word_t       p_r, p_nxt;
  word_t       sum_r, sum_nxt;
  word_t       umc_r, umc_nxt;
  word_t       upc_r, upc_nxt;
  word_t       hm_r, hm_nxt;
  word_t       hp_r, hp_nxt;

  logic [CFG_W-1:0] gamma_r, light_r;

  // per-species state, indexed by species
  word_t       st_vx_r [2];
  word_t       st_vy_r [2];
  word_t       st_vz_r [2];
  word_t       st_c_r  [2];
  word_t       st_h_r  [2];
  word_t       st_q_r  [2];
  logic        st_we;

  word_t       out_res_r [6];
  logic        out_valid_r, out_valid_nxt;
  logic        out_fault_r, out_sat_r;
  logic        out_load;

  word_t       mul_a, mul_b;
  prod_t       prod;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  sqrt_req_t   sqrt_req;
  sqrt_rsp_t   sqrt_rsp;

  word_t       g, cl;
  word_t       u1, u2, u3, cs, hs, qs;

  tfrep_mul u_mul (
    .clk    (clk),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_r (prod)
  );

  tfrep_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  tfrep_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  assign g  = {1'b0, gamma_r};
  assign cl = {1'b0, light_r};
  assign u1 = st_vx_r[sp_r];
  assign u2 = st_vy_r[sp_r];
  assign u3 = st_vz_r[sp_r];
  assign cs = st_c_r[sp_r];
  assign hs = st_h_r[sp_r];
  assign qs = st_q_r[sp_r];

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    acc_t  x;
    word_t t;
    state_nxt = state_r;
    step_nxt  = step_r;
    op_nxt    = op_r;
    sp_nxt    = sp_r;
    fault_nxt = fault_r;
    flag_nxt  = flag_r;
    acc_nxt   = acc_r;
    tmp_nxt   = tmp_r;
    p_nxt     = p_r;
    sum_nxt   = sum_r;
    umc_nxt   = umc_r;
    upc_nxt   = upc_r;
    hm_nxt    = hm_r;
    hp_nxt    = hp_r;
    for (int i = 0; i < 6; i++) begin
      w_nxt[i] = w_r[i];
      r_nxt[i] = r_r[i];
    end
    st_we         = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    mul_a         = '0;
    mul_b         = '0;
    div_req       = '{start: 1'b0, num: tmp_r, den: w_r[0]};
    sqrt_req      = '{start: 1'b0, arg: '0};
    x             = '0;
    t             = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          sp_nxt    = in_species;
          w_nxt[0]  = in_val_0;
          w_nxt[1]  = in_val_1;
          w_nxt[2]  = in_val_2;
          w_nxt[3]  = in_val_3;
          w_nxt[4]  = in_val_4;
          w_nxt[5]  = in_val_5;
          fault_nxt = 1'b0;
          flag_nxt  = 1'b0;
          step_nxt  = '0;
          case (in_opcode)
            OP_LOAD: begin
              if (in_val_0 <= 0) begin
                fault_nxt = 1'b1;
                state_nxt = S_FAULT;
              end else begin
                state_nxt = S_RUN;
              end
            end
            OP_FLUID, OP_FIELD: state_nxt = S_RUN;
            default: begin
              for (int i = 0; i < 6; i++) r_nxt[i] = '0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_FAULT: begin
        // report the kept state of the species
        r_nxt[0]  = u1;
        r_nxt[1]  = u2;
        r_nxt[2]  = u3;
        r_nxt[3]  = cs;
        r_nxt[4]  = hs;
        r_nxt[5]  = qs;
        state_nxt = S_DONE;
      end

      S_WAIT: begin
        if (div_rsp.done || sqrt_rsp.done) begin
          state_nxt = S_RUN;
          step_nxt  = step_r + 5'd1;
        end
      end

      S_RUN: begin
        step_nxt = step_r + 5'd1;
        case (op_r)
          OP_LOAD: begin
            case (step_r)
              5'd0: begin
                div_req.start = 1'b1;
                div_req.num   = w_r[1];
                state_nxt     = S_WAIT;
                step_nxt      = step_r;
              end
              5'd1: begin
                r_nxt[0]      = div_rsp.q;
                flag_nxt      = flag_r | div_rsp.ovf;
                div_req.start = 1'b1;
                div_req.num   = w_r[2];
                state_nxt     = S_WAIT;
                step_nxt      = step_r;
              end
              5'd2: begin
                r_nxt[1]      = div_rsp.q;
                flag_nxt      = flag_r | div_rsp.ovf;
                div_req.start = 1'b1;
                div_req.num   = w_r[3];
                state_nxt     = S_WAIT;
                step_nxt      = step_r;
              end
              5'd3: begin
                r_nxt[2] = div_rsp.q;
                flag_nxt = flag_r | div_rsp.ovf;
                mul_a    = r_r[0];
                mul_b    = r_r[0];
              end
              5'd4: begin
                acc_nxt = ext_p(prod);
                mul_a   = r_r[1];
                mul_b   = r_r[1];
              end
              5'd5: begin
                acc_nxt = acc_r + ext_p(prod);
                mul_a   = r_r[2];
                mul_b   = r_r[2];
              end
              5'd6: acc_nxt = acc_r + ext_p(prod);
              5'd7: begin
                t        = sat_w(acc_r);
                flag_nxt = flag_r | ovf_w(acc_r);
                r_nxt[5] = t >>> 1;
              end
              5'd8: begin
                mul_a = w_r[0];
                mul_b = r_r[5];
              end
              5'd9: begin
                x        = ext_p(prod);
                tmp_nxt  = sat_w(x);
                flag_nxt = flag_r | ovf_w(x);
              end
              5'd10: begin
                x        = ext_w(w_r[4]) - ext_w(tmp_r);
                tmp_nxt  = sat_w(x);
                flag_nxt = flag_r | ovf_w(x);
              end
              5'd11: begin
                x        = ext_w(g) - ONE_ACC;
                flag_nxt = flag_r | ovf_w(x);
                mul_a    = sat_w(x);
                mul_b    = tmp_r;
              end
              5'd12: begin
                x        = ext_p(prod);
                p_nxt    = sat_w(x);
                flag_nxt = flag_r | ovf_w(x);
              end
              5'd13: begin
                mul_a = g;
                mul_b = p_r;
              end
              5'd14: begin
                x        = ext_p(prod);
                tmp_nxt  = sat_w(x);
                flag_nxt = flag_r | ovf_w(x);
              end
              5'd15: begin
                div_req.start = 1'b1;
                state_nxt     = S_WAIT;
                step_nxt      = step_r;
              end
              5'd16: begin
                // magnitude of gamma*p/rho; the most negative word clips
                flag_nxt = flag_r | div_rsp.ovf;
                if (div_rsp.q == WMIN) begin
                  flag_nxt = 1'b1;
                  t        = WMAX;
                end else begin
                  t = div_rsp.q[WORD_W-1] ? -div_rsp.q : div_rsp.q;
                end
                sqrt_req.start = 1'b1;
                sqrt_req.arg   = t[WORD_W-2:0];
                state_nxt      = S_WAIT;
                step_nxt       = step_r;
              end
              5'd17: begin
                r_nxt[3] = sqrt_rsp.root;
                x        = ext_w(w_r[4]) + ext_w(p_r);
                tmp_nxt  = sat_w(x);
                flag_nxt = flag_r | ovf_w(x);
              end
              5'd18: begin
                div_req.start = 1'b1;
                state_nxt     = S_WAIT;
                step_nxt      = step_r;
              end
              default: begin
                r_nxt[4]  = div_rsp.q;
                flag_nxt  = flag_r | div_rsp.ovf;
                st_we     = 1'b1;
                state_nxt = S_DONE;
              end
            endcase
          end

          OP_FLUID: begin
            case (step_r)
              5'd0: begin
                x        = ext_w(w_r[0]) + ext_w(w_r[1]) + ext_w(w_r[4]);
                sum_nxt  = sat_w(x);
                flag_nxt = flag_r | ovf_w(x);
                x        = ext_w(u1) - ext_w(cs);
                umc_nxt  = sat_w(x);
                flag_nxt = flag_nxt | ovf_w(x);
                x        = ext_w(u1) + ext_w(cs);
                upc_nxt  = sat_w(x);
                flag_nxt = flag_nxt | ovf_w(x);
                mul_a    = u1;
                mul_b    = cs;
              end
              5'd1: begin
                x        = ext_p(prod);
                tmp_nxt  = sat_w(x);
                flag_nxt = flag_r | ovf_w(x);
                mul_a    = umc_r;
                mul_b    = w_r[0];
              end
              5'd2: begin
                x        = ext_w(hs) - ext_w(tmp_r);
                hm_nxt   = sat_w(x);
                flag_nxt = flag_r | ovf_w(x);
                x        = ext_w(hs) + ext_w(tmp_r);
                hp_nxt   = sat_w(x);
                flag_nxt = flag_nxt | ovf_w(x);
                acc_nxt  = ext_p(prod);
                mul_a    = u1;
                mul_b    = w_r[1];
              end
              5'd3: begin
                acc_nxt = acc_r + ext_p(prod);
                mul_a   = upc_r;
                mul_b   = w_r[4];
              end
              5'd4: acc_nxt = acc_r + ext_p(prod);
              5'd5: begin
                r_nxt[1] = sat_w(acc_r);
                flag_nxt = flag_r | ovf_w(acc_r);
                mul_a    = hm_r;
                mul_b    = w_r[0];
              end
              5'd6: begin
                acc_nxt = ext_p(prod);
                mul_a   = qs;
                mul_b   = w_r[1];
              end
              5'd7: begin
                acc_nxt = acc_r + ext_p(prod);
                mul_a   = u2;
                mul_b   = w_r[2];
              end
              5'd8: begin
                acc_nxt = acc_r + ext_p(prod);
                mul_a   = u3;
                mul_b   = w_r[3];
              end
              5'd9: begin
                acc_nxt = acc_r + ext_p(prod);
                mul_a   = hp_r;
                mul_b   = w_r[4];
              end
              5'd10: acc_nxt = acc_r + ext_p(prod);
              5'd11: begin
                r_nxt[0] = sum_r;
                r_nxt[4] = sat_w(acc_r);
                flag_nxt = flag_r | ovf_w(acc_r);
                mul_a    = u2;
                mul_b    = sum_r;
              end
              5'd12: begin
                x        = ext_p(prod) + ext_w(w_r[2]);
                r_nxt[2] = sat_w(x);
                flag_nxt = flag_r | ovf_w(x);
                mul_a    = u3;
                mul_b    = sum_r;
              end
              default: begin
                x         = ext_p(prod) + ext_w(w_r[3]);
                r_nxt[3]  = sat_w(x);
                flag_nxt  = flag_r | ovf_w(x);
                r_nxt[5]  = '0;
                state_nxt = S_DONE;
              end
            endcase
          end

          OP_FIELD: begin
            case (step_r)
              5'd0: begin
                x        = ext_w(w_r[5]) - ext_w(w_r[1]);
                tmp_nxt  = sat_w(x);
                flag_nxt = flag_r | ovf_w(x);
                x        = ext_w(w_r[0]) - ext_w(w_r[4]);
                hm_nxt   = sat_w(x);
                flag_nxt = flag_nxt | ovf_w(x);
                x        = ext_w(w_r[0]) + ext_w(w_r[4]);
                r_nxt[1] = sat_w(x);
                flag_nxt = flag_nxt | ovf_w(x);
                x        = ext_w(w_r[1]) + ext_w(w_r[5]);
                r_nxt[2] = sat_w(x);
                flag_nxt = flag_nxt | ovf_w(x);
                r_nxt[0] = w_r[2];
                r_nxt[3] = w_r[3];
              end
              5'd1: begin
                mul_a = cl;
                mul_b = tmp_r;
              end
              5'd2: begin
                x        = ext_p(prod);
                r_nxt[4] = sat_w(x);
                flag_nxt = flag_r | ovf_w(x);
                mul_a    = cl;
                mul_b    = hm_r;
              end
              default: begin
                x         = ext_p(prod);
                r_nxt[5]  = sat_w(x);
                flag_nxt  = flag_r | ovf_w(x);
                state_nxt = S_DONE;
              end
            endcase
          end

          default: state_nxt = S_DONE;
        endcase
      end

      S_DONE: begin
        // advance into the output register once it is free or being taken
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      gamma_r     <= GAMMA_RST;
      light_r     <= LIGHT_RST;
      for (int s = 0; s < 2; s++) begin
        st_vx_r[s] <= '0;
        st_vy_r[s] <= '0;
        st_vz_r[s] <= '0;
        st_c_r[s]  <= '0;
        st_h_r[s]  <= '0;
        st_q_r[s]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAMMA: gamma_r <= cfg_data;
          CFG_LIGHT: light_r <= cfg_data;
          default: ;
        endcase
      end
      if (st_we) begin
        st_vx_r[sp_r] <= r_r[0];
        st_vy_r[sp_r] <= r_r[1];
        st_vz_r[sp_r] <= r_r[2];
        st_c_r[sp_r]  <= r_r[3];
        st_h_r[sp_r]  <= r_nxt[4];
        st_q_r[sp_r]  <= r_r[5];
      end
    end
    op_r    <= op_nxt;
    sp_r    <= sp_nxt;
    fault_r <= fault_nxt;
    flag_r  <= flag_nxt;
    acc_r   <= acc_nxt;
    tmp_r   <= tmp_nxt;
    p_r     <= p_nxt;
    sum_r   <= sum_nxt;
    umc_r   <= umc_nxt;
    upc_r   <= upc_nxt;
    hm_r    <= hm_nxt;
    hp_r    <= hp_nxt;
    for (int i = 0; i < 6; i++) begin
      w_r[i] <= w_nxt[i];
      r_r[i] <= r_nxt[i];
    end
    if (out_load) begin
      for (int i = 0; i < 6; i++) out_res_r[i] <= r_r[i];
      out_fault_r <= fault_r;
      out_sat_r   <= flag_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_res_0         = out_res_r[0];
  assign out_res_1         = out_res_r[1];
  assign out_res_2         = out_res_r[2];
  assign out_res_3         = out_res_r[3];
  assign out_res_4         = out_res_r[4];
  assign out_res_5         = out_res_r[5];
  assign out_density_fault = out_fault_r;
  assign out_saturated     = out_sat_r;

endmodule
`default_nettype wire

### rtl/core/tfrep_checker.sv
// Port-level checker for the eigen projection top, attached by bind.
// Depends on tfrep_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module tfrep_checker import tfrep_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire word_t            out_res_0,
  input wire word_t            out_res_5,
  input wire logic             out_density_fault,
  input wire logic             out_saturated
);

  // an accepted beat keeps the block busy for at least the next cycle
  `ASSERT_CLK(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "accept did not raise stall")

  // a density fault reports kept state, never a clip
  `ASSERT_CLK(a_fault_no_sat, clk, rst_n, (out_valid && out_density_fault) |-> !out_saturated, "fault beat flagged saturation")

  // a stalled result beat stays valid and holds out_res_0 and out_res_5
  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_res_0) && $stable(out_res_5)), "stalled result changed")

  // reset empties the output register
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind two_fluid_right_eigen_projection_top tfrep_checker u_tfrep_checker (.*);
`default_nettype wire

### sim/testbench.sv
// Self-checking bench for two_fluid_right_eigen_projection_top: random and directed beats,
// in-order result checks against a behavioral Q16.16 predictor.
// Depends on tfrep_pkg and the block's RTL.
module testbench;
  import tfrep_pkg::*;

  // Behavioral predictor state and saturation helpers.
  class eigen_scoreboard;
    longint vx[2], vy[2], vz[2], cs[2], hh[2], qq[2];
    longint gamma_q, light_q;
    bit sat_flag;
    logic [193:0] pending[$];
    int errors;

    function new();
      gamma_q = 109227; light_q = 65536; errors = 0;
      for (int s = 0; s < 2; s++) begin
        vx[s] = 0; vy[s] = 0; vz[s] = 0; cs[s] = 0; hh[s] = 0; qq[s] = 0;
      end
    endfunction

    function longint clip(longint x);
      if (x > 64'sd2147483647) begin
        sat_flag = 1; return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
        sat_flag = 1; return -64'sd2147483648;
      end
      return x;
    endfunction

    function longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      return p >>> 16;  // arithmetic shift floors toward minus infinity
    endfunction

    function longint qdiv(longint num, longint den);
      bit neg;
      longint unsigned mag, q, r, d, cap;
      neg = num < 0;
      mag = neg ? -num : num;
      d = den; cap = 64'd2147483648;
      q = mag / d; r = mag % d;
      for (int i = 0; i < 16 && q <= cap; i++) begin
        r = r << 1; q = q << 1;
        if (r >= d) begin
          r = r - d; q = q | 1;
        end
      end
      if (q > cap) q = cap + 1;
      return clip(neg ? -longint'(q) : longint'(q));
    endfunction

    function longint qsqrt(longint x);
      longint unsigned v, rem, root;
      v = longint'(x) << 16;
      rem = 0; root = 0;
      for (int i = 23; i >= 0; i--) begin
        rem = (rem << 2) | ((v >> (2 * i)) & 3);
        root = root << 1;
        if (rem >= ((root << 1) | 1)) begin
          rem = rem - ((root << 1) | 1); root = root | 1;
        end
      end
      return clip(root);
    endfunction

    // Note an accepted input beat: predict and queue its result.
    function void note_input(logic [1:0] op, logic sp, word_t v[6]);
      longint w[6], r[6];
      bit fault;
      longint rho, e, u1, u2, u3, um2, half, kin, gm1, p, t, sum, umc, upc, uc, hm, hp;
      fault = 0; sat_flag = 0;
      for (int i = 0; i < 6; i++) begin
        w[i] = v[i]; r[i] = 0;
      end
      if (op == OP_LOAD) begin
        rho = w[0];
        if (rho <= 0) begin
          fault = 1;
        end else begin
          e = w[4];
          u1 = qdiv(w[1], rho); u2 = qdiv(w[2], rho); u3 = qdiv(w[3], rho);
          um2 = clip(qmul(u1, u1) + qmul(u2, u2) + qmul(u3, u3));
          half = um2 >>> 1;
          kin = clip(qmul(rho, half));
          gm1 = clip(gamma_q - 65536);
          p = clip(qmul(gm1, clip(e - kin)));
          t = qdiv(clip(qmul(gamma_q, p)), rho);
          t = clip(t < 0 ? -t : t);
          vx[sp] = u1; vy[sp] = u2; vz[sp] = u3;
          cs[sp] = qsqrt(t);
          hh[sp] = qdiv(clip(e + p), rho);
          qq[sp] = half;
        end
        r[0] = vx[sp]; r[1] = vy[sp]; r[2] = vz[sp];
        r[3] = cs[sp]; r[4] = hh[sp]; r[5] = qq[sp];
      end else if (op == OP_FLUID) begin
        sum = clip(w[0] + w[1] + w[4]);
        umc = clip(vx[sp] - cs[sp]); upc = clip(vx[sp] + cs[sp]);
        uc = clip(qmul(vx[sp], cs[sp]));
        hm = clip(hh[sp] - uc); hp = clip(hh[sp] + uc);
        r[0] = sum;
        r[1] = clip(qmul(umc, w[0]) + qmul(vx[sp], w[1]) + qmul(upc, w[4]));
        r[2] = clip(qmul(vy[sp], sum) + w[2]);
        r[3] = clip(qmul(vz[sp], sum) + w[3]);
        r[4] = clip(qmul(hm, w[0]) + qmul(qq[sp], w[1]) + qmul(vy[sp], w[2])
                    + qmul(vz[sp], w[3]) + qmul(hp, w[4]));
      end else if (op == OP_FIELD) begin
        r[0] = w[2];
        r[1] = clip(w[0] + w[4]);
        r[2] = clip(w[1] + w[5]);
        r[3] = w[3];
        r[4] = clip(qmul(light_q, clip(w[5] - w[1])));
        r[5] = clip(qmul(light_q, clip(w[0] - w[4])));
      end else begin
        sat_flag = 0;
      end
      pending.push_back({fault, sat_flag, word_t'(r[5]), word_t'(r[4]), word_t'(r[3]),
                         word_t'(r[2]), word_t'(r[1]), word_t'(r[0])});
    endfunction

    // Compare one accepted result beat with the oldest prediction.
    function void check_result(logic [193:0] got);
      logic [193:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 6; i++)
        if (want[32*i +: 32] !== got[32*i +: 32]) begin
          $display("%0t: res_%0d expected %h actual %h", $time, i,
                   want[32*i +: 32], got[32*i +: 32]);
          errors++;
        end
      if (want[192] !== got[193]) begin
        $display("%0t: saturated expected %b actual %b", $time, want[192], got[193]);
        errors++;
      end
      if (want[193] !== got[192]) begin
        $display("%0t: density_fault expected %b actual %b", $time, want[193], got[192]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, in_species = 0;
  logic [1:0] in_opcode = OP_LOAD;
  word_t in_val_0 = 0, in_val_1 = 0, in_val_2 = 0, in_val_3 = 0, in_val_4 = 0, in_val_5 = 0;
  logic out_valid, out_stall = 1, out_density_fault, out_saturated;
  word_t out_res_0, out_res_1, out_res_2, out_res_3, out_res_4, out_res_5;
  logic cfg_we = 0, cfg_index = CFG_GAMMA;
  logic [CFG_W-1:0] cfg_data = 0;

  eigen_scoreboard board = new();
  bit hold_off_out = 0;
  bit feed_done = 0;
  int unsigned cycle_count = 0;

  always #5 clk = ~clk;

  two_fluid_right_eigen_projection_top uut (.*);

  // Abort on a runaway run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 6000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sample accepted result beats.
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      board.check_result({out_saturated, out_density_fault, out_res_5, out_res_4,
                          out_res_3, out_res_2, out_res_1, out_res_0});

  // Receiver: random stall per beat; hold off fully while the long stretch runs.
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0 || hold_off_out) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
        while (hold_off_out) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk iff out_valid);
    end
  end

  // Long receiver hold-off counted in its own process.
  initial begin
    wait (feed_done == 0 && cycle_count > 400);
    hold_off_out = 1;
    repeat (3000) @(posedge clk);
    hold_off_out = 0;
  end

  // Offer one beat and hold it until accepted.
  task send_beat(logic [1:0] op, logic sp, word_t v[6], bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_opcode <= op; in_species <= sp;
    in_val_0 <= v[0]; in_val_1 <= v[1]; in_val_2 <= v[2];
    in_val_3 <= v[3]; in_val_4 <= v[4]; in_val_5 <= v[5];
    @(posedge clk iff !in_stall);
    board.note_input(op, sp, v);
  endtask

  // Drain: drop valid and wait for every expected result, then the tail latency.
  task drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_GAMMA) board.gamma_q = val;
    else board.light_q = val;
    @(posedge clk);
  endtask

  function word_t rand_word(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 65536 * 64) - 65536 * 32;
      2: return $urandom_range(1, 65536 * 16);
      default: return ($urandom_range(0, 1) ? WMAX : WMIN);
    endcase
  endfunction

  task random_phase(int count);
    word_t v[6];
    logic [1:0] op;
    int mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 9);
      op = (mode < 3) ? OP_LOAD : (mode < 8) ? OP_FLUID : (mode < 9) ? OP_FIELD : OP_UNUSED;
      for (int i = 0; i < 6; i++)
        v[i] = rand_word($urandom_range(0, 9) < 6 ? 1 : ($urandom_range(0, 5) == 0 ? 3 : 0));
      // Loads mostly get a sane positive density.
      if (op == OP_LOAD && $urandom_range(0, 9) < 8) v[0] = rand_word(2);
      send_beat(op, $urandom_range(0, 1), v);
    end
  endtask

  initial begin
    word_t v[6];
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, every opcode, faults, unused opcode.
    v = '{65536, 131072, -65536, 32768, 655360, 0};
    send_beat(OP_LOAD, 0, v);
    v = '{32768, -65536, 65536, 0, 327680, 0};
    send_beat(OP_LOAD, 1, v);
    v = '{0, 1, 2, 3, 4, 5};
    send_beat(OP_LOAD, 0, v);
    v = '{WMIN, WMAX, WMAX, WMIN, WMAX, WMIN};
    send_beat(OP_LOAD, 1, v);
    v = '{1, WMAX, WMIN, WMAX, WMIN, 0};
    send_beat(OP_LOAD, 1, v);
    v = '{WMAX, WMAX, WMAX, WMAX, WMAX, WMAX};
    send_beat(OP_LOAD, 0, v);
    v = '{65536, 65536, 65536, 65536, 65536, 65536};
    send_beat(OP_FLUID, 0, v);
    send_beat(OP_FLUID, 1, v);
    send_beat(OP_FIELD, 0, v);
    send_beat(OP_UNUSED, 1, v);
    v = '{WMAX, WMAX, WMIN, WMIN, WMAX, WMIN};
    send_beat(OP_FLUID, 0, v);
    send_beat(OP_FIELD, 1, v);
    send_beat(OP_UNUSED, 0, v);
    v = '{-1, -1, -1, -1, -1, -1};
    send_beat(OP_FIELD, 0, v);
    send_beat(OP_LOAD, 0, v);
    drain();

    // Sweep configuration, extremes included.
    write_reg(CFG_GAMMA, '1);
    write_reg(CFG_LIGHT, '1);
    random_phase(250);
    drain();
    write_reg(CFG_GAMMA, 0);
    write_reg(CFG_LIGHT, 0);
    random_phase(250);
    drain();
    write_reg(CFG_GAMMA, 98304);
    write_reg(CFG_LIGHT, $urandom_range(1, 65536 * 8));
    random_phase(500);
    drain();
    write_reg(CFG_GAMMA, $urandom());
    write_reg(CFG_LIGHT, $urandom());
    random_phase(400);
    drain();
    write_reg(CFG_GAMMA, 109227);
    write_reg(CFG_LIGHT, 65536);
    random_phase(500);

    drain();
    feed_done = 1;
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### two_fluid_right_eigen_projection_top.f
+incdir+rtl/core
rtl/core/tfrep_pkg.sv
rtl/core/tfrep_mul.sv
rtl/core/tfrep_div.sv
rtl/core/tfrep_sqrt.sv
rtl/core/two_fluid_right_eigen_projection_top.sv
rtl/core/tfrep_checker.sv
sim/testbench.sv
